// ===== hw/rtl/sws_pkg.sv =====
// Shared types and codes for the sliding window sorter.
package sws_pkg;

	// Fixed widths of the stream fields.
	localparam int unsigned FIELD_BITS = 32;
	localparam int unsigned S_DATA_BITS = 64;
	localparam int unsigned M_DATA_BITS = 64;
	localparam int unsigned CFG_DATA_BITS = 6;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_END  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ORDERED = 2'd0,
		KIND_PASSED  = 2'd1,
		KIND_HALT    = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_WINDOW_SIZE = 1'b0,
		REG_SOFT_BREAK  = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		DP_HOLD       = 3'd0,
		DP_INSERT     = 3'd1,
		DP_INSERT_REL = 3'd2,
		DP_POP        = 3'd3,
		DP_PASS       = 3'd4
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
		kind_t  kind;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_zero;
	} dp_status_t;

endpackage

// ===== hw/rtl/sliding_window_sorter.sv =====
// Push: any result that a push request causes appears in the cycle after the request is accepted.
// Throughput: one push request per cycle while the output register is free or being taken.
// End: the window drains one held item per cycle from cell 0 while the output register is free or being taken,
// and the next request is taken only once every held item has left.
// Reset clears the fill count, the halt flag, the output valid and the configuration
// (window size 8, hard mode); the window cells themselves are not reset.
module sliding_window_sorter #(
	parameter int unsigned WINDOW_MAX = 32,
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned TAG_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [sws_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sws_pkg::S_DATA_BITS-1:0]     s_tdata,  // sort_key [31:0], item_tag [63:32]
	input  logic                                s_tuser,  // opcode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sws_pkg::M_DATA_BITS-1:0]     m_tdata,  // out_key [31:0], out_tag [63:32]
	output logic [1:0]                          m_tuser,  // out_kind
	output logic                                m_tlast
);

	localparam int unsigned FILL_BITS = $clog2(WINDOW_MAX + 1);
	localparam int unsigned FB = sws_pkg::FIELD_BITS;

	sws_pkg::dp_cmd_t cmd;
	sws_pkg::dp_status_t status;
	sws_pkg::kind_t out_kind;
	logic [FILL_BITS-1:0] fill;
	logic [FB-1:0] out_key, out_tag;

	sws_ctrl #(
		.WINDOW_MAX (WINDOW_MAX),
		.FILL_BITS  (FILL_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.fill      (fill),
		.status    (status)
	);

	sws_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.KEY_BITS   (KEY_BITS),
		.TAG_BITS   (TAG_BITS),
		.FILL_BITS  (FILL_BITS)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.fill     (fill),
		.in_key   (s_tdata[FB-1:0]),
		.in_tag   (s_tdata[2*FB-1:FB]),
		.status   (status),
		.out_key  (out_key),
		.out_tag  (out_tag),
		.out_kind (out_kind),
		.out_last (m_tlast)
	);

	assign m_tdata = {out_tag, out_key};
	assign m_tuser = out_kind;

endmodule

// ===== hw/rtl/sws_datapath.sv =====
// Datapath: a row of compare-and-shift cells holding the window, and the output register.
module sws_datapath #(
	parameter int unsigned WINDOW_MAX = 32,
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned TAG_BITS   = 32,
	parameter int unsigned FILL_BITS  = 6
) (
	input  logic                           clk,
	input  sws_pkg::dp_cmd_t               cmd,
	input  logic [FILL_BITS-1:0]           fill,
	input  logic [sws_pkg::FIELD_BITS-1:0] in_key,
	input  logic [sws_pkg::FIELD_BITS-1:0] in_tag,
	output sws_pkg::dp_status_t            status,
	output logic [sws_pkg::FIELD_BITS-1:0] out_key,
	output logic [sws_pkg::FIELD_BITS-1:0] out_tag,
	output sws_pkg::kind_t                 out_kind,
	output logic                           out_last
);

	localparam int unsigned N = WINDOW_MAX;
	localparam int unsigned FB = sws_pkg::FIELD_BITS;

	logic [KEY_BITS-1:0] key_q [N];
	logic [TAG_BITS-1:0] tag_q [N];
	logic [KEY_BITS+FB-1:0] key_wide;
	logic [TAG_BITS+FB-1:0] tag_wide;
	logic [KEY_BITS-1:0] new_key;
	logic [TAG_BITS-1:0] new_tag;
	logic [N:0] cmp;

	logic [KEY_BITS-1:0] sel_key;
	logic [TAG_BITS-1:0] sel_tag;
	logic [KEY_BITS+FB-1:0] sel_key_wide;
	logic [TAG_BITS+FB-1:0] sel_tag_wide;
	logic [FB-1:0] out_key_q;
	logic [FB-1:0] out_tag_q;
	sws_pkg::kind_t out_kind_q;
	logic out_last_q;

	// Keys and tags are taken modulo their storage width.
	assign key_wide = {{KEY_BITS{1'b0}}, in_key};
	assign tag_wide = {{TAG_BITS{1'b0}}, in_tag};
	assign new_key = key_wide[KEY_BITS-1:0];
	assign new_tag = tag_wide[TAG_BITS-1:0];

	// The cells are sorted, so cmp is a run of ones from cell 0 up to the insert point.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cmp[i] = (FILL_BITS'(i) < fill) && ($signed(key_q[i]) <= $signed(new_key));
		end
		cmp[N] = 1'b0;
	end

	assign status.pos_zero = !cmp[0];

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [KEY_BITS-1:0] up_key, down_key, nxt_key;
		logic [TAG_BITS-1:0] up_tag, down_tag, nxt_tag;
		logic prev_cmp;

		if (g == 0) begin : g_first
			assign down_key = new_key;
			assign down_tag = new_tag;
			assign prev_cmp = 1'b1;
		end else begin : g_inner
			assign down_key = key_q[g-1];
			assign down_tag = tag_q[g-1];
			assign prev_cmp = cmp[g-1];
		end

		if (g == N - 1) begin : g_top
			assign up_key = key_q[g];
			assign up_tag = tag_q[g];
		end else begin : g_lower
			assign up_key = key_q[g+1];
			assign up_tag = tag_q[g+1];
		end

		always_comb begin
			nxt_key = key_q[g];
			nxt_tag = tag_q[g];
			case (cmd.op)
				sws_pkg::DP_INSERT: begin
					if (!cmp[g]) begin
						nxt_key = prev_cmp ? new_key : down_key;
						nxt_tag = prev_cmp ? new_tag : down_tag;
					end
				end
				sws_pkg::DP_INSERT_REL: begin
					// Cell 0 leaves; the cells below the insert point move down one place.
					if (cmp[g+1]) begin
						nxt_key = up_key;
						nxt_tag = up_tag;
					end else if (cmp[g]) begin
						nxt_key = new_key;
						nxt_tag = new_tag;
					end
				end
				sws_pkg::DP_POP: begin
					nxt_key = up_key;
					nxt_tag = up_tag;
				end
				default: begin
				end
			endcase
		end

		always_ff @(posedge clk) begin
			key_q[g] <= nxt_key;
			tag_q[g] <= nxt_tag;
		end
	end

	assign sel_key = (cmd.op == sws_pkg::DP_PASS) ? new_key : key_q[0];
	assign sel_tag = (cmd.op == sws_pkg::DP_PASS) ? new_tag : tag_q[0];
	assign sel_key_wide = {{FB{sel_key[KEY_BITS-1]}}, sel_key};
	assign sel_tag_wide = {{FB{1'b0}}, sel_tag};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_key_q <= sel_key_wide[FB-1:0];
			out_tag_q <= sel_tag_wide[FB-1:0];
			out_kind_q <= cmd.kind;
			out_last_q <= cmd.last;
		end
	end

	assign out_key = out_key_q;
	assign out_tag = out_tag_q;
	assign out_kind = out_kind_q;
	assign out_last = out_last_q;

endmodule

// ===== hw/rtl/sws_ctrl.sv =====
// Controller: configuration registers, fill count, halt flag and the push/drain state machine.
module sws_ctrl #(
	parameter int unsigned WINDOW_MAX = 32,
	parameter int unsigned FILL_BITS  = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [0:0]                        cfg_index,
	input  logic [sws_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_opcode,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sws_pkg::dp_cmd_t                  cmd,
	output logic [FILL_BITS-1:0]              fill,
	input  sws_pkg::dp_status_t               status
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic [sws_pkg::CFG_DATA_BITS-1:0] window_size_q;
	logic soft_break_q;
	logic [FILL_BITS-1:0] fill_q, fill_d;
	logic halted_q, halted_d;
	logic out_valid_q;
	logic [FILL_BITS-1:0] eff_size;
	logic out_free, accept, over_full;

	always_comb begin
		if (window_size_q == '0) begin
			eff_size = FILL_BITS'(1);
		end else if ({1'b0, window_size_q} > 7'(WINDOW_MAX)) begin
			eff_size = FILL_BITS'(WINDOW_MAX);
		end else begin
			eff_size = FILL_BITS'(window_size_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept = in_valid && in_ready;
	assign over_full = fill_q >= eff_size;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		halted_d = halted_q;
		cmd.op = sws_pkg::DP_HOLD;
		cmd.load_out = 1'b0;
		cmd.kind = sws_pkg::KIND_ORDERED;
		cmd.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept && !halted_q) begin
					if (in_opcode == sws_pkg::OP_END) begin
						if (fill_q != '0) begin
							state_d = ST_DRAIN;
						end
					end else if (over_full && fill_q != '0 && status.pos_zero) begin
						// The new item is below everything held: the window was too small.
						cmd.op = sws_pkg::DP_PASS;
						cmd.load_out = 1'b1;
						if (soft_break_q) begin
							cmd.kind = sws_pkg::KIND_PASSED;
						end else begin
							cmd.kind = sws_pkg::KIND_HALT;
							halted_d = 1'b1;
						end
					end else if (over_full) begin
						cmd.op = sws_pkg::DP_INSERT_REL;
						cmd.load_out = 1'b1;
					end else begin
						cmd.op = sws_pkg::DP_INSERT;
						fill_d = fill_q + FILL_BITS'(1);
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					cmd.op = sws_pkg::DP_POP;
					cmd.load_out = 1'b1;
					cmd.last = (fill_q == FILL_BITS'(1));
					fill_d = fill_q - FILL_BITS'(1);
					if (fill_q == FILL_BITS'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			halted_q <= halted_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= sws_pkg::CFG_DATA_BITS'(8);
			soft_break_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sws_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data;
				sws_pkg::REG_SOFT_BREAK: soft_break_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign fill = fill_q;

endmodule

// ===== verif/tb.sv =====
// Testbench for the sliding window sorter: directed and random streams checked against a built-in predictor.
module tb;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_PER_PHASE = 55;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] tag;
	} entry_t;

	typedef struct packed {
		logic [31:0]     key;
		logic [31:0]     tag;
		sws_pkg::kind_t  kind;
		logic            last;
	} release_t;

	class order_scoreboard;
		entry_t   window[$];
		release_t due_releases[$];
		logic [5:0] size_reg;
		bit       soft_mode;
		bit       halted;
		int       errors;

		function new();
			size_reg = 6'd8;
			soft_mode = 1'b0;
			halted = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function int unsigned held_limit();
			if (size_reg == 0)
				return 1;
			if (size_reg > 32)
				return 32;
			return size_reg;
		endfunction

		// Number of held items that a new key goes after; equal keys stay older-first.
		function int unsigned insert_pos(logic [31:0] key);
			int unsigned pos;
			pos = 0;
			while (pos < window.size() && $signed(window[pos].key) <= $signed(key))
				pos++;
			return pos;
		endfunction

		function bit would_break(logic [31:0] key);
			return window.size() + 1 > held_limit() && window.size() > 0 &&
				insert_pos(key) == 0;
		endfunction

		task note_config(sws_pkg::reg_index_t idx, logic [5:0] data);
			if (idx == sws_pkg::REG_WINDOW_SIZE)
				size_reg = data;
			else
				soft_mode = data[0];
		endtask

		task predict_release(sws_pkg::opcode_t op, logic [31:0] key, logic [31:0] tag);
			int unsigned pos;
			entry_t fresh;
			if (halted)
				return;
			if (op == sws_pkg::OP_END) begin
				while (window.size() > 0) begin
					due_releases.push_back({window[0].key, window[0].tag,
						sws_pkg::KIND_ORDERED, window.size() == 1});
					void'(window.pop_front());
				end
				return;
			end
			if (would_break(key)) begin
				if (soft_mode) begin
					due_releases.push_back({key, tag, sws_pkg::KIND_PASSED, 1'b1});
				end else begin
					halted = 1'b1;
					due_releases.push_back({key, tag, sws_pkg::KIND_HALT, 1'b1});
				end
				return;
			end
			pos = insert_pos(key);
			fresh.key = key;
			fresh.tag = tag;
			window.insert(pos, fresh);
			// A lowered size only sheds one item per push.
			if (window.size() > held_limit()) begin
				due_releases.push_back({window[0].key, window[0].tag,
					sws_pkg::KIND_ORDERED, 1'b1});
				void'(window.pop_front());
			end
		endtask

		task check_release(logic [31:0] key, logic [31:0] tag, sws_pkg::kind_t kind,
			logic last);
			release_t want;
			if (due_releases.size() == 0) begin
				report($sformatf("unexpected result key %h tag %h", key, tag));
				return;
			end
			want = due_releases.pop_front();
			if (key !== want.key)
				report($sformatf("key %h, wanted %h", key, want.key));
			if (tag !== want.tag)
				report($sformatf("tag %h, wanted %h", tag, want.tag));
			if (kind !== want.kind)
				report($sformatf("kind %0d, wanted %0d", kind, want.kind));
			if (last !== want.last)
				report($sformatf("last %b, wanted %b", last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // sort_key [31:0], item_tag [63:32]
	logic        s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;  // out_key [31:0], out_tag [63:32]
	logic [1:0]  m_tuser;  // out_kind
	logic        m_tlast;

	order_scoreboard sb;
	bit          quiet;
	int unsigned cycle_count = 0;
	logic [31:0] cursor;

	sliding_window_sorter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_release(m_tdata[31:0], m_tdata[63:32], sws_pkg::kind_t'(m_tuser),
				m_tlast);
		m_tready <= quiet || $urandom_range(0, 99) >= 16;
	end

	// Valid stays high after acceptance; it is lowered only by a gap or by settle_requests.
	task send_request(sws_pkg::opcode_t op, logic [31:0] key, logic [31:0] tag);
		while (!quiet && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {tag, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.predict_release(op, key, tag);
	endtask

	task settle_requests();
		s_tvalid <= 1'b0;
		while (sb.due_releases.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_register(sws_pkg::reg_index_t idx, logic [5:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly a nearly sorted stream, with some wild keys and drains mixed in.
	task random_request(bit avoid_break);
		logic [31:0] key;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		cursor = cursor + $urandom_range(0, 8);
		if (roll < 8) begin
			send_request(sws_pkg::OP_END, $urandom, $urandom);
		end else begin
			if (roll < 18)
				key = $urandom;
			else
				key = cursor + $urandom_range(0, 40) - 20;
			if (avoid_break && sb.would_break(key))
				key = sb.window[0].key;
			send_request(sws_pkg::OP_PUSH, key, $urandom);
		end
	endtask

	initial begin
		int unsigned sizes[7];
		bit          softs[7];
		logic [5:0]  soft_word;
		sizes = '{1, 32, 0, 63, 3, 17, 4};
		softs = '{1, 0, 1, 1, 1, 0, 0};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sws_pkg::REG_WINDOW_SIZE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = sws_pkg::OP_PUSH;
		quiet = 1'b0;
		cursor = $urandom;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(sws_pkg::REG_WINDOW_SIZE, 6'd8);
		write_register(sws_pkg::REG_SOFT_BREAK, 6'd0);
		send_request(sws_pkg::OP_END, 32'h0, 32'h0);
		send_request(sws_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(sws_pkg::OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(sws_pkg::OP_PUSH, 32'h0000_0000, 32'h0000_0001);
		send_request(sws_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0002);
		for (int i = 10; i < 15; i++)
			send_request(sws_pkg::OP_PUSH, 32'd5, i);
		send_request(sws_pkg::OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle_requests();

		for (int p = 0; p < 7; p++) begin
			soft_word = 6'($urandom);
			soft_word[0] = softs[p];
			write_register(sws_pkg::REG_WINDOW_SIZE, 6'(sizes[p]));
			write_register(sws_pkg::REG_SOFT_BREAK, soft_word);
			quiet = p == 1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				random_request(!softs[p]);
			settle_requests();
		end

		// Hard mode with window size 4: a key below a full window halts the block for good.
		send_request(sws_pkg::OP_END, 32'h0, 32'h0);
		for (int i = 0; i < 5; i++)
			send_request(sws_pkg::OP_PUSH, 100 + i, $urandom);
		send_request(sws_pkg::OP_PUSH, 32'h8000_0000, $urandom);
		for (int n = 0; n < 10; n++)
			random_request(1'b0);
		send_request(sws_pkg::OP_END, 32'h0, 32'h0);
		settle_requests();
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/sws_pkg.sv
hw/rtl/sws_datapath.sv
hw/rtl/sws_ctrl.sv
hw/rtl/sliding_window_sorter.sv
verif/tb.sv
